/* rtl/core/text_console_cursor_buffer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor buffer
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_BUFFER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_BUFFER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TCCB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TCCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCCB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TCCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/tccb_pkg.sv */
// ----------------------------------------------------------------------------
// Text console cursor buffer package
// Shared constants, character codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tccb_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic latch;
        logic exec;
        logic clr_en;
        logic clr_all;
    } t_dp_cmd;

    typedef struct packed {
        logic scroll;
        logic clr_last;
    } t_dp_sts;

endpackage

/* rtl/core/tccb_datapath.sv */
// ----------------------------------------------------------------------------
// Text console cursor buffer datapath
// Character store with a rotating top row, cursor registers and clear counter.
// ----------------------------------------------------------------------------
module tccb_datapath #(
    parameter int COLS = tccb_pkg::DEF_COLS,
    parameter int ROWS = tccb_pkg::DEF_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tccb_pkg::t_dp_cmd            i_cmd,
    output tccb_pkg::t_dp_sts            o_sts,
    input  logic                         i_req_type,
    input  logic [tccb_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tccb_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tccb_pkg::COL_W-1:0]   i_read_col,
    output logic [tccb_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tccb_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tccb_pkg::ROW_W-1:0]   o_cursor_row,
    output logic                         o_did_scroll
);
    import tccb_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int XW    = $clog2(COLS);
    localparam int YW    = $clog2(ROWS);
    localparam int AW    = $clog2(DEPTH);

    // The store is addressed by physical row; logical row zero sits at r_top.
    function automatic logic [YW-1:0] phys_row(input logic [YW-1:0] lrow,
                                               input logic [YW-1:0] top);
        logic [YW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (YW+1)'(ROWS)) begin
            sum = sum - (YW+1)'(ROWS);
        end
        return sum[YW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] prow,
                                                input logic [XW-1:0] col);
        return AW'(AW'(prow) * AW'(COLS)) + AW'(col);
    endfunction

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    logic              r_req;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;

    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [YW-1:0] r_top, n_top;
    logic          r_scrolled, n_scrolled;
    logic [AW-1:0] r_clr_base, n_clr_base;
    logic [AW-1:0] r_clr_cnt, n_clr_cnt;

    logic          x_last, y_last, top_last;
    logic          is_lf, is_cr, is_put, do_scroll;
    logic          rd_ok, rd_en, put_wr, we;
    logic [AW-1:0] cur_addr, rd_addr, clr_addr, waddr;
    logic [CHAR_W-1:0] wdata;

    assign x_last   = (r_x == XW'(COLS - 1));
    assign y_last   = (r_y == YW'(ROWS - 1));
    assign top_last = (r_top == YW'(ROWS - 1));
    assign is_put   = (r_req == REQ_PUT);
    assign is_lf    = is_put && (r_char == CH_LF);
    assign is_cr    = is_put && (r_char == CH_CR);
    assign do_scroll = is_put && y_last && (is_lf || (!is_cr && x_last));

    assign rd_ok    = (32'(r_row) < ROWS) && (32'(r_col) < COLS);
    assign rd_en    = i_cmd.exec && (r_req == REQ_READ) && rd_ok;
    assign put_wr   = i_cmd.exec && is_put && !is_lf && !is_cr;
    assign cur_addr = cell_addr(phys_row(r_y, r_top), r_x);
    assign rd_addr  = cell_addr(phys_row(YW'(r_row), r_top), XW'(r_col));
    assign clr_addr = r_clr_base + r_clr_cnt;

    assign we    = i_cmd.clr_en || put_wr;
    assign waddr = i_cmd.clr_en ? clr_addr : cur_addr;
    assign wdata = i_cmd.clr_en ? '0 : r_char;

    assign o_sts.scroll   = do_scroll;
    assign o_sts.clr_last = i_cmd.clr_all ? (r_clr_cnt == AW'(DEPTH - 1))
                                          : (r_clr_cnt == AW'(COLS - 1));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_char <= i_char_code;
            r_row  <= i_read_row;
            r_col  <= i_read_col;
        end
    end

    always_comb begin
        n_x        = r_x;
        n_y        = r_y;
        n_top      = r_top;
        n_scrolled = r_scrolled;
        n_clr_base = r_clr_base;
        n_clr_cnt  = r_clr_cnt;
        if (i_cmd.latch) begin
            n_scrolled = 1'b0;
        end
        if (i_cmd.clr_en) begin
            n_clr_cnt = r_clr_cnt + 1'b1;
        end
        if (i_cmd.exec && is_put) begin
            if (is_lf) begin
                if (!y_last) begin
                    n_y = r_y + 1'b1;
                end
            end else if (is_cr) begin
                n_x = '0;
            end else if (x_last) begin
                n_x = '0;
                if (!y_last) begin
                    n_y = r_y + 1'b1;
                end
            end else begin
                n_x = r_x + 1'b1;
            end
            if (do_scroll) begin
                n_scrolled = 1'b1;
                n_top      = top_last ? '0 : r_top + 1'b1;
                n_clr_base = cell_addr(r_top, '0);
                n_clr_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_top      <= '0;
            r_scrolled <= 1'b0;
            r_clr_base <= '0;
            r_clr_cnt  <= '0;
        end else begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_top      <= n_top;
            r_scrolled <= n_scrolled;
            r_clr_base <= n_clr_base;
            r_clr_cnt  <= n_clr_cnt;
        end
    end

    assign o_cell_char  = ((r_req == REQ_READ) && rd_ok) ? r_rd_data : '0;
    assign o_cursor_col = COL_W'(r_x);
    assign o_cursor_row = ROW_W'(r_y);
    assign o_did_scroll = r_scrolled;

endmodule

/* rtl/core/tccb_ctrl.sv */
// ----------------------------------------------------------------------------
// Text console cursor buffer controller
// Sequences the store clear, request execution, row clear and result strobe.
// ----------------------------------------------------------------------------
`include "text_console_cursor_buffer_top_macros.svh"

module tccb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    output tccb_pkg::t_dp_cmd o_cmd,
    input  tccb_pkg::t_dp_sts i_sts
);
    import tccb_pkg::*;

    typedef enum logic [2:0] {
        S_CLR_ALL,
        S_IDLE,
        S_EXEC,
        S_CLR_ROW,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.latch   = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.clr_en  = 1'b0;
        o_cmd.clr_all = 1'b0;
        case (r_state)
            S_CLR_ALL: begin
                o_cmd.clr_en  = 1'b1;
                o_cmd.clr_all = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.scroll ? S_CLR_ROW : S_DONE;
            end
            S_CLR_ROW: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_ALL;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_DONE);
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;

    `TCCB_ASSERT_NEXT(a_valid_one_cycle, i_clk, i_rst_n, r_valid, !r_valid)
    `TCCB_ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, r_valid, !r_busy)
    `TCCB_ASSERT_NEXT(a_accept_executes, i_clk, i_rst_n, start && !r_busy, r_state == S_EXEC)
    `TCCB_ASSERT_SAME(a_busy_matches_state, i_clk, i_rst_n, 1'b1, r_busy == (r_state != S_IDLE))

endmodule

/* rtl/core/text_console_cursor_buffer_top.sv */
// ----------------------------------------------------------------------------
// Text console cursor buffer
// Character store with cursor, line feed, carriage return and scrolling.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low. A put word (req_type 0) places a character or handles line feed and
// carriage return; a read word (req_type 1) returns one stored cell, or zero
// when the row or column is out of range. Each request gives exactly one
// result word, shown on the o_ ports for one cycle with o_valid high; the
// receiver cannot hold it off. A request without scrolling passes through an
// execute state and then a done state, in which the result is shown; busy
// drops in the cycle after the result, and no new request is taken before
// then. A scroll rotates the top row pointer and clears the new bottom row
// through the single memory write port, one cell per cycle, before the result.
// After reset the block clears all ROWS * COLS cells of the store with busy
// held high; the cursor starts at row zero, column zero.
// ----------------------------------------------------------------------------
module text_console_cursor_buffer_top #(
    parameter int COLS = tccb_pkg::DEF_COLS,
    parameter int ROWS = tccb_pkg::DEF_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [tccb_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tccb_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tccb_pkg::COL_W-1:0]   i_read_col,
    output logic                         o_valid,
    output logic [tccb_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tccb_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tccb_pkg::ROW_W-1:0]   o_cursor_row,
    output logic                         o_did_scroll
);
    import tccb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tccb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    tccb_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cell_char  (o_cell_char),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_did_scroll (o_did_scroll)
    );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the text console cursor buffer
// Sends put and read request words from a queue, predicts each result word
// with a behavioral copy of the character store and cursor, and checks every
// result word field by field against the prediction, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import tccb_pkg::*;

    localparam int COLS = DEF_COLS;
    localparam int ROWS = DEF_ROWS;
    localparam int RANDOM_WORDS = 1850;
    localparam int QUIET_TAIL = 200;
    localparam int MAX_REPORTS = 20;

    typedef struct {
        logic              req;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        int                gap;
        bit                drain;
    } t_console_request;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scroll;
    } t_console_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = 1'b0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ROW_W-1:0]  i_read_row = '0;
    logic [COL_W-1:0]  i_read_col = '0;
    logic              o_valid;
    logic [CHAR_W-1:0] o_cell_char;
    logic [COL_W-1:0]  o_cursor_col;
    logic [ROW_W-1:0]  o_cursor_row;
    logic              o_did_scroll;

    t_console_request  pending_requests[$];
    t_console_result   expected_words[$];
    logic [CHAR_W-1:0] screen[0:ROWS*COLS-1];
    int                cur_col;
    int                cur_row;
    int                n_sent = 0;
    int                n_checked = 0;
    int                n_errors = 0;
    int                gap_left = 0;
    bit                gappy = 1'b0;

    text_console_cursor_buffer_top #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_char_code(i_char_code),
        .i_read_row(i_read_row),
        .i_read_col(i_read_col),
        .o_valid(o_valid),
        .o_cell_char(o_cell_char),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row),
        .o_did_scroll(o_did_scroll)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic console_line_down();
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            return 1'b0;
        end
        cur_row = ROWS - 1;
        for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
            screen[i] = screen[i + COLS];
        end
        for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) begin
            screen[i] = '0;
        end
        return 1'b1;
    endfunction

    function automatic t_console_result console_apply(input logic req,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ROW_W-1:0] rr,
                                                      input logic [COL_W-1:0] rc);
        t_console_result res;
        res = '0;
        if (req == REQ_READ) begin
            if (int'(rr) < ROWS && int'(rc) < COLS) begin
                res.cell_char = screen[int'(rr) * COLS + int'(rc)];
            end
        end else if (ch == CH_LF) begin
            res.scroll = console_line_down();
        end else if (ch == CH_CR) begin
            cur_col = 0;
        end else begin
            screen[cur_row * COLS + cur_col] = ch;
            cur_col++;
            if (cur_col >= COLS) begin
                res.scroll = console_line_down();
                cur_col = 0;
            end
        end
        res.col = cur_col[COL_W-1:0];
        res.row = cur_row[ROW_W-1:0];
        return res;
    endfunction

    task automatic add_request(input logic req, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                               input bit drain);
        t_console_request item;
        item.req = req;
        item.ch = ch;
        item.row = rr;
        item.col = rc;
        item.gap = (gappy && $urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : 0;
        item.drain = drain;
        pending_requests.push_back(item);
    endtask

    task automatic add_put(input logic [CHAR_W-1:0] ch, input bit drain);
        add_request(REQ_PUT, ch, ROW_W'($urandom), COL_W'($urandom), drain);
    endtask

    task automatic add_read(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                            input bit drain);
        add_request(REQ_READ, CHAR_W'($urandom), rr, rc, drain);
    endtask

    always @(posedge i_clk) begin : driver
        logic            nxt_start;
        int              in_flight;
        t_console_result res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt_start = start;
            in_flight = n_sent - n_checked;
            if (start && !busy) begin
                res = console_apply(i_req_type, i_char_code, i_read_row, i_read_col);
                expected_words.push_back(res);
                n_sent <= n_sent + 1;
                in_flight++;
                void'(pending_requests.pop_front());
                gap_left = (pending_requests.size() > 0) ? pending_requests[0].gap : 0;
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain && in_flight > 0)) begin
                    i_req_type <= pending_requests[0].req;
                    i_char_code <= pending_requests[0].ch;
                    i_read_row <= pending_requests[0].row;
                    i_read_col <= pending_requests[0].col;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_console_result want;
        if (i_rst_n && o_valid) begin
            if (n_checked >= n_sent) begin
                if (n_errors < MAX_REPORTS) begin
                    $display("%0t: unexpected word: char %0d col %0d row %0d scroll %0d",
                             $time, o_cell_char, o_cursor_col, o_cursor_row, o_did_scroll);
                end
                n_errors++;
            end else begin
                want = expected_words[n_checked];
                if (o_cell_char !== want.cell_char || o_cursor_col !== want.col ||
                    o_cursor_row !== want.row || o_did_scroll !== want.scroll) begin
                    if (n_errors < MAX_REPORTS) begin
                        $display("%0t: word %0d expected char %0d col %0d row %0d scroll %0d,",
                                 $time, n_checked, want.cell_char, want.col, want.row,
                                 want.scroll);
                        $display("    got char %0d col %0d row %0d scroll %0d",
                                 o_cell_char, o_cursor_col, o_cursor_row, o_did_scroll);
                    end
                    n_errors++;
                end
                n_checked <= n_checked + 1;
            end
        end
    end

    initial begin
        int random_count;
        int kind;
        int len;
        int waited;
        for (int i = 0; i < ROWS * COLS; i++) begin
            screen[i] = '0;
        end
        cur_col = 0;
        cur_row = 0;

        add_read(5'd0, 7'd0, 1'b0);
        add_put(8'h00, 1'b0);
        add_put(8'hFF, 1'b0);
        add_put("A", 1'b0);
        add_read(5'd0, 7'd0, 1'b0);
        add_read(5'd0, 7'd1, 1'b0);
        add_read(5'd0, 7'd2, 1'b0);
        add_put(CH_CR, 1'b0);
        add_put("B", 1'b0);
        add_read(5'd0, 7'd0, 1'b0);
        add_put(CH_LF, 1'b0);
        add_put("C", 1'b0);
        add_put(CH_CR, 1'b0);
        add_put(CH_LF, 1'b0);
        add_read(5'd1, 7'd1, 1'b0);
        add_read(5'd24, 7'd79, 1'b0);
        add_read(5'd25, 7'd0, 1'b0);
        add_read(5'd0, 7'd80, 1'b0);
        add_read(5'd31, 7'd127, 1'b0);
        add_request(REQ_PUT, 8'h7E, 5'd31, 7'd127, 1'b0);

        random_count = 0;
        while (random_count < RANDOM_WORDS) begin
            gappy = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 120);
                    for (int i = 0; i < len; i++) begin
                        add_put(CHAR_W'($urandom_range(32, 126)),
                                random_count == 0 && i == 0);
                    end
                    random_count += len;
                    kind = $urandom_range(0, 19);
                    if (kind < 14) begin
                        add_put(CH_CR, 1'b0);
                        add_put(CH_LF, 1'b0);
                        random_count += 2;
                    end else if (kind < 17) begin
                        add_put(CH_LF, 1'b0);
                        random_count++;
                    end
                end
                4, 5: begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 4) != 0) begin
                            add_read(ROW_W'($urandom_range(0, ROWS - 1)),
                                     COL_W'($urandom_range(0, COLS - 1)), 1'b0);
                        end else begin
                            add_read(ROW_W'($urandom), COL_W'($urandom), 1'b0);
                        end
                    end
                    random_count += len;
                end
                6: begin
                    len = $urandom_range(1, 30);
                    for (int i = 0; i < len; i++) begin
                        add_put(CH_LF, 1'b0);
                    end
                    random_count += len;
                end
                7: begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++) begin
                        add_request(1'($urandom), CHAR_W'($urandom), ROW_W'($urandom),
                                    COL_W'($urandom), 1'b0);
                    end
                    random_count += len;
                end
                8: begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        add_read(ROW_W'($urandom_range(ROWS - 5, ROWS - 1)),
                                 COL_W'($urandom_range(0, COLS - 1)),
                                 i == 0 && $urandom_range(0, 9) == 0);
                    end
                    random_count += len;
                end
                default: begin
                    add_put($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
                    random_count++;
                end
            endcase
        end
        for (int i = pending_requests.size() - QUIET_TAIL; i < pending_requests.size(); i++) begin
            pending_requests[i].gap = 0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start) begin
            @(negedge i_clk);
        end
        waited = 0;
        while (n_checked != n_sent && waited < 4 * (COLS + 10)) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (2 * COLS + 20) @(negedge i_clk);

        if (n_errors == 0 && n_checked == n_sent) begin
            $display("[text_console_cursor_buffer_top] OK");
        end else begin
            if (n_checked != n_sent) begin
                $display("%0t: %0d expected result words never arrived", $time,
                         n_sent - n_checked);
            end
            $display("[text_console_cursor_buffer_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[text_console_cursor_buffer_top] ERROR");
        $finish;
    end

endmodule
